/* design/ihss_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes for the image header size sniffer.
// No dependencies; imported by every module of the block.
package ihss_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int HDR_BYTES   = 24;
    localparam int WIN_BYTES   = 12;
    localparam int CFG_BITS    = 16;
    localparam int DIM_BITS    = 32;
    localparam int TDATA_BITS  = 72;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_APP0   = 8'hE0;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOF1   = 8'hC1;
    localparam logic [7:0] MARK_SOF2   = 8'hC2;
    localparam logic [7:0] MARK_SOF3   = 8'hC3;
    localparam logic [7:0] MARK_SOF9   = 8'hC9;
    localparam logic [7:0] MARK_SOF10  = 8'hCA;
    localparam logic [7:0] MARK_SOF11  = 8'hCB;
    localparam logic [7:0] PNG_SIG0    = 8'h89;

    localparam logic [CFG_BITS-1:0] DEFAULT_DIM = 16'd640;

    typedef enum logic [1:0] {
        FMT_JPEG    = 2'd0,
        FMT_GIF     = 2'd1,
        FMT_PNG     = 2'd2,
        FMT_DEFAULT = 2'd3
    } fmt_t;

    typedef enum logic {
        CFG_DEFAULT_WIDTH  = 1'b0,
        CFG_DEFAULT_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef logic [HDR_BYTES-1:0][7:0] hdr_t;
    typedef logic [WIN_BYTES-1:0][7:0] win_t;

    typedef struct packed {
        logic fire;        // last beat of a file taken this cycle
        logic short_file;  // fewer than 24 bytes seen
    } walk_status_t;

    typedef struct packed {
        fmt_t                fmt;
        logic [DIM_BITS-1:0] height;
        logic [DIM_BITS-1:0] width;
    } result_t;

    typedef struct packed {
        logic room;        // buffer takes another result
    } buf_status_t;

endpackage

/* design/ihss_header_walk.sv */
`timescale 1ns / 1ps
// Header capture, recent-byte window and JFIF segment walk state.
// Depends on ihss_pkg.
module ihss_header_walk
    import ihss_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         beat_en,
    input  logic [7:0]   data_byte,
    input  logic         end_of_file,
    output hdr_t         hdr_next,
    output walk_status_t status
);

    hdr_t                   hdr_reg;
    win_t                   win_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] target_reg;
    logic                   active_reg;
    logic                   stopped_reg;

    hdr_t                   hdr_cap;
    win_t                   win_next;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [OFFSET_BITS-1:0] target_next;
    logic                   active_next;
    logic                   stopped_next;

    logic                   jfif_hit;
    logic                   snap_hit;
    logic                   adv_en;
    logic [OFFSET_BITS-1:0] adv_base;
    logic [7:0]             seg_m0;
    logic [7:0]             seg_m1;
    logic [7:0]             seg_m2;
    logic [7:0]             seg_m3;
    logic                   seg_stop;
    logic [OFFSET_BITS+1:0] seg_sum;
    logic                   not_sat;

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m == MARK_SOF0) || (m == MARK_SOF1) || (m == MARK_SOF2) ||
               (m == MARK_SOF3) || (m == MARK_SOF9) || (m == MARK_SOF10) ||
               (m == MARK_SOF11);
    endfunction

    always_comb begin
        win_next = {data_byte, win_reg[WIN_BYTES-1:1]};
        not_sat  = (offset_reg != OFFSET_MAX);

        hdr_cap = hdr_reg;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (not_sat && offset_reg == OFFSET_BITS'(i)) begin
                hdr_cap[i] = data_byte;
            end
        end

        jfif_hit = not_sat && (offset_reg == OFFSET_BITS'(9)) &&
                   !active_reg && !stopped_reg &&
                   hdr_reg[0] == MARK_PREFIX && hdr_reg[1] == MARK_SOI &&
                   hdr_reg[2] == MARK_PREFIX && hdr_reg[3] == MARK_APP0 &&
                   hdr_reg[6] == 8'h4A && hdr_reg[7] == 8'h46 &&
                   hdr_reg[8] == 8'h49 && data_byte == 8'h46;
        snap_hit = not_sat && !jfif_hit && active_reg && (offset_reg == target_reg);
        adv_en   = jfif_hit || snap_hit;

        // The first segment sits at bytes 2..5; later ones come from the window.
        if (jfif_hit) begin
            adv_base = OFFSET_BITS'(13);
            seg_m0   = hdr_reg[2];
            seg_m1   = hdr_reg[3];
            seg_m2   = hdr_reg[4];
            seg_m3   = hdr_reg[5];
        end else begin
            adv_base = target_reg;
            seg_m0   = win_next[0];
            seg_m1   = win_next[1];
            seg_m2   = win_next[2];
            seg_m3   = win_next[3];
        end

        seg_stop = (seg_m0 != MARK_PREFIX) || is_frame_marker(seg_m1);
        seg_sum  = {2'b00, adv_base} + (OFFSET_BITS+2)'({seg_m2, seg_m3})
                 + (OFFSET_BITS+2)'(2);

        hdr_next     = hdr_cap;
        target_next  = target_reg;
        active_next  = active_reg;
        stopped_next = stopped_reg;
        offset_next  = not_sat ? offset_reg + OFFSET_BITS'(1) : offset_reg;

        if (snap_hit) begin
            hdr_next[WIN_BYTES+1:2] = win_next;
        end
        if (adv_en) begin
            if (seg_stop) begin
                active_next  = 1'b0;
                stopped_next = 1'b1;
            end else begin
                active_next = 1'b1;
                target_next = (seg_sum[OFFSET_BITS+1:OFFSET_BITS] != 2'b00)
                            ? OFFSET_MAX : seg_sum[OFFSET_BITS-1:0];
            end
        end

        status.fire       = beat_en && end_of_file;
        status.short_file = (offset_next < OFFSET_BITS'(HDR_BYTES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg     <= '0;
            win_reg     <= '0;
            offset_reg  <= '0;
            target_reg  <= '0;
            active_reg  <= 1'b0;
            stopped_reg <= 1'b0;
        end else if (beat_en) begin
            if (end_of_file) begin
                hdr_reg     <= '0;
                win_reg     <= '0;
                offset_reg  <= '0;
                target_reg  <= '0;
                active_reg  <= 1'b0;
                stopped_reg <= 1'b0;
            end else begin
                hdr_reg     <= hdr_next;
                win_reg     <= win_next;
                offset_reg  <= offset_next;
                target_reg  <= target_next;
                active_reg  <= active_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

/* design/ihss_fmt_decode.sv */
`timescale 1ns / 1ps
// Format recognition and dimension extraction from the 24 header bytes.
// Depends on ihss_pkg.
module ihss_fmt_decode
    import ihss_pkg::*;
(
    input  hdr_t                hdr,
    input  logic                short_file,
    input  logic [CFG_BITS-1:0] default_width,
    input  logic [CFG_BITS-1:0] default_height,
    output result_t             result
);

    logic is_jpeg;
    logic is_gif;
    logic is_png;

    always_comb begin
        is_jpeg = hdr[0] == MARK_PREFIX && hdr[1] == MARK_SOI && hdr[2] == MARK_PREFIX;
        is_gif  = hdr[0] == 8'h47 && hdr[1] == 8'h49 && hdr[2] == 8'h46;
        is_png  = hdr[0] == PNG_SIG0 && hdr[1] == 8'h50 && hdr[2] == 8'h4E &&
                  hdr[3] == 8'h47 && hdr[4] == 8'h0D && hdr[5] == 8'h0A &&
                  hdr[6] == 8'h1A && hdr[7] == 8'h0A && hdr[12] == 8'h49 &&
                  hdr[13] == 8'h48 && hdr[14] == 8'h44 && hdr[15] == 8'h52;

        result.fmt    = FMT_DEFAULT;
        result.width  = DIM_BITS'(default_width);
        result.height = DIM_BITS'(default_height);
        if (!short_file) begin
            if (is_jpeg) begin
                result.fmt    = FMT_JPEG;
                result.height = DIM_BITS'({hdr[7], hdr[8]});
                result.width  = DIM_BITS'({hdr[9], hdr[10]});
            end else if (is_gif) begin
                result.fmt    = FMT_GIF;
                result.width  = DIM_BITS'({hdr[7], hdr[6]});
                result.height = DIM_BITS'({hdr[9], hdr[8]});
            end else if (is_png) begin
                result.fmt    = FMT_PNG;
                result.width  = {hdr[16], hdr[17], hdr[18], hdr[19]};
                result.height = {hdr[20], hdr[21], hdr[22], hdr[23]};
            end
        end
    end

endmodule

/* design/ihss_out_buf.sv */
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
// Depends on ihss_pkg.
module ihss_out_buf
    import ihss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  result_t     push_data,
    input  logic        pop_ready,
    output logic        out_valid,
    output result_t     out_data,
    output buf_status_t status
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;

    always_comb begin
        pop             = out_valid_reg && pop_ready;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_reg;
    assign status.room = !skid_valid_reg;

endmodule

/* design/image_header_size_sniffer_unit.sv */
`timescale 1ns / 1ps
// Image header size sniffer: top level.
// Depends on ihss_pkg, ihss_header_walk, ihss_fmt_decode, ihss_out_buf.
//
// Usage:
//   Stream an image file into the s_ channel one byte per beat, with s_tlast
//   high on the final byte. Each file yields exactly one m_ beat carrying the
//   width, height and format found in its header (JPEG frame, GIF screen,
//   PNG IHDR), or the configured default size when the file is shorter than
//   24 bytes or not recognized. JFIF JPEGs are walked segment by segment.
//   The cfg_ port sets the default width (index 0) and height (index 1);
//   write it only while no file is in flight.
// Throughput: one byte per cycle while the result buffer has room; a new file
//   may start on the cycle after the previous last byte.
// Result path: the result is registered into the output buffer on the last
//   byte's beat; the capture/walk logic and the format decode sit between the
//   header state registers and the result register.
// Stall: the result register is backed by a skid register, so bytes keep
//   flowing while one result waits; s_tready drops only when two results
//   are held, and rises again once m_ takes one.
// Reset: aresetn (synchronous, active low) clears the header state, empties
//   the result buffer and restores both defaults to 640.
module image_header_size_sniffer_unit
    import ihss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // end_of_file
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // [31:0] image_width, [63:32] image_height,
                                             // [65:64] format_code, [71:66] zero
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_wdata
);

    logic [CFG_BITS-1:0] def_width_reg;
    logic [CFG_BITS-1:0] def_height_reg;

    logic         beat_en;
    hdr_t         hdr_next;
    walk_status_t walk_status;
    result_t      result;
    result_t      out_result;
    buf_status_t  buf_status;

    // Take a byte whenever the result buffer still has room.
    assign s_tready = buf_status.room;
    assign beat_en  = s_tvalid && s_tready;

    // Hold the default size; writes land directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_width_reg  <= DEFAULT_DIM;
            def_height_reg <= DEFAULT_DIM;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEFAULT_WIDTH:  def_width_reg  <= cfg_wdata;
                CFG_DEFAULT_HEIGHT: def_height_reg <= cfg_wdata;
                default:            def_width_reg  <= def_width_reg;
            endcase
        end
    end

    // Capture header bytes and advance the JFIF walk.
    ihss_header_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_en     (beat_en),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .hdr_next    (hdr_next),
        .status      (walk_status)
    );

    // Decode the header as it stands after the current byte.
    ihss_fmt_decode u_decode (
        .hdr            (hdr_next),
        .short_file     (walk_status.short_file),
        .default_width  (def_width_reg),
        .default_height (def_height_reg),
        .result         (result)
    );

    // Register the result on the last byte and hold it through stalls.
    ihss_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (walk_status.fire),
        .push_data (result),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .status    (buf_status)
    );

    assign m_tdata = {(TDATA_BITS-DIM_BITS*2-2)'(0), out_result.fmt,
                      out_result.height, out_result.width};

endmodule

/* design/ihss_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for image_header_size_sniffer_unit, bound to the top.
// Depends on ihss_pkg.
module ihss_checker
    import ihss_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [7:0]            s_tdata,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic                  cfg_wr_en,
    input logic                  cfg_index,
    input logic [CFG_BITS-1:0]   cfg_wdata
);

    // Reset empties the result buffer.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A held result stays put while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A new result follows a last-byte beat of the cycle before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without last byte");

    // Input stalls only while a result is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // Only PNG carries dimensions wider than 16 bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] != FMT_PNG) |->
            m_tdata[31:16] == 16'd0 && m_tdata[63:48] == 16'd0)
        else $error("wide dimension on non-PNG result");

endmodule

bind image_header_size_sniffer_unit ihss_checker u_ihss_checker (.*);

/* dv/image_header_size_sniffer_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for image_header_size_sniffer_unit: streams whole image files,
// predicts the reported size per file, and checks every m_ beat. Depends on ihss_pkg.

// Eight-byte PNG file signature, first byte in the top bits
localparam logic [63:0] PNG_SIGNATURE = {ihss_pkg::PNG_SIG0, "PNG", 8'h0D, 8'h0A, 8'h1A, 8'h0A};

function automatic bit is_frame_marker(logic [7:0] m);
    return m == ihss_pkg::MARK_SOF0 || m == ihss_pkg::MARK_SOF1 ||
           m == ihss_pkg::MARK_SOF2 || m == ihss_pkg::MARK_SOF3 ||
           m == ihss_pkg::MARK_SOF9 || m == ihss_pkg::MARK_SOF10 ||
           m == ihss_pkg::MARK_SOF11;
endfunction

// Tracks the header state of the file in flight and queues the size each file reports.
class size_tracker;
    ihss_pkg::hdr_t                   head;
    ihss_pkg::win_t                   recent;
    logic [ihss_pkg::OFFSET_BITS-1:0] count;
    logic [ihss_pkg::OFFSET_BITS-1:0] seg_end;
    bit                               walking;
    bit                               walk_done;
    logic [15:0]                      dflt_w;
    logic [15:0]                      dflt_h;
    ihss_pkg::result_t                sizes_due[$];
    int                               errors;

    function new();
        dflt_w = ihss_pkg::DEFAULT_DIM;
        dflt_h = ihss_pkg::DEFAULT_DIM;
        errors = 0;
        restart();
    endfunction

    function void restart();
        head      = '0;
        recent    = '0;
        count     = '0;
        seg_end   = '0;
        walking   = 1'b0;
        walk_done = 1'b0;
    endfunction

    function void set_default(ihss_pkg::cfg_idx_t idx, logic [15:0] v);
        if (idx == ihss_pkg::CFG_DEFAULT_WIDTH)
            dflt_w = v;
        else
            dflt_h = v;
    endfunction

    // Stop at a frame marker or a missing prefix, else move to the next segment start.
    function void next_segment();
        logic [ihss_pkg::OFFSET_BITS:0] nxt;
        if (head[2] != ihss_pkg::MARK_PREFIX || is_frame_marker(head[3])) begin
            walking   = 1'b0;
            walk_done = 1'b1;
        end else begin
            nxt = {1'b0, seg_end} + (ihss_pkg::OFFSET_BITS+1)'(2)
                + (ihss_pkg::OFFSET_BITS+1)'({head[4], head[5]});
            if (nxt > {1'b0, ihss_pkg::OFFSET_MAX})
                nxt = {1'b0, ihss_pkg::OFFSET_MAX};
            seg_end = nxt[ihss_pkg::OFFSET_BITS-1:0];
            walking = 1'b1;
        end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
        ihss_pkg::result_t r;
        recent = {b, recent[11:1]};
        if (count != ihss_pkg::OFFSET_MAX) begin
            if (count < 24)
                head[count] = b;
            if (count == 9 && !walking && !walk_done &&
                head[0] == ihss_pkg::MARK_PREFIX && head[1] == ihss_pkg::MARK_SOI &&
                head[2] == ihss_pkg::MARK_PREFIX && head[3] == ihss_pkg::MARK_APP0 &&
                {head[6], head[7], head[8], head[9]} == "JFIF") begin
                seg_end = 13;
                next_segment();
            end else if (walking && count == seg_end) begin
                head[13:2] = recent;
                next_segment();
            end
            count = count + 1;
        end
        if (!last)
            return;

        r = '0;
        if (count < 24) begin
            r.width  = {16'd0, dflt_w};
            r.height = {16'd0, dflt_h};
            r.fmt    = ihss_pkg::FMT_DEFAULT;
        end else if (head[0] == ihss_pkg::MARK_PREFIX && head[1] == ihss_pkg::MARK_SOI &&
                     head[2] == ihss_pkg::MARK_PREFIX) begin
            r.height = {16'd0, head[7], head[8]};
            r.width  = {16'd0, head[9], head[10]};
            r.fmt    = ihss_pkg::FMT_JPEG;
        end else if ({head[0], head[1], head[2]} == "GIF") begin
            r.width  = {16'd0, head[7], head[6]};
            r.height = {16'd0, head[9], head[8]};
            r.fmt    = ihss_pkg::FMT_GIF;
        end else if ({head[0], head[1], head[2], head[3], head[4], head[5], head[6], head[7]}
                         == PNG_SIGNATURE &&
                     {head[12], head[13], head[14], head[15]} == "IHDR") begin
            r.width  = {head[16], head[17], head[18], head[19]};
            r.height = {head[20], head[21], head[22], head[23]};
            r.fmt    = ihss_pkg::FMT_PNG;
        end else begin
            r.width  = {16'd0, dflt_w};
            r.height = {16'd0, dflt_h};
            r.fmt    = ihss_pkg::FMT_DEFAULT;
        end
        sizes_due.push_back(r);
        restart();
    endfunction

    function void check_size(logic [ihss_pkg::TDATA_BITS-1:0] beat);
        ihss_pkg::result_t want;
        if (sizes_due.size() == 0) begin
            $error("result beat with no file pending: tdata %h", beat);
            errors++;
            return;
        end
        want = sizes_due.pop_front();
        if (beat[31:0] !== want.width) begin
            $error("image_width: expected %0d, actual %0d", want.width, beat[31:0]);
            errors++;
        end
        if (beat[63:32] !== want.height) begin
            $error("image_height: expected %0d, actual %0d", want.height, beat[63:32]);
            errors++;
        end
        if (beat[65:64] !== want.fmt) begin
            $error("format_code: expected %0d, actual %0d", want.fmt, beat[65:64]);
            errors++;
        end
        if (beat[71:66] !== '0) begin
            $error("tdata padding: expected 0, actual %h", beat[71:66]);
            errors++;
        end
    endfunction
endclass

module image_header_size_sniffer_unit_test;
    import ihss_pkg::*;

    localparam int LIMIT       = 400000;  // cycles; the watchdog ends the run here
    localparam int PHASE_BYTES = 240;     // bytes of random files per register setting
    localparam int MAX_FILE    = 80;      // long segment lengths are cut here, mid-walk

    typedef enum int {
        F_SHORT,
        F_NOISE,
        F_GIF,
        F_PNG,
        F_JPEG,
        F_JFIF
    } file_kind_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  cfg_wr_en;
    logic                  cfg_index;
    logic [CFG_BITS-1:0]   cfg_wdata;

    logic [7:0]  file_buf[$];   // file being built, first byte at the front
    size_tracker tracker;
    bit          tx_idle;       // sender may insert gaps
    bit          rx_idle;       // receiver may insert stalls
    int          hold_cycles = 0;
    int          cycle_count = 0;

    image_header_size_sniffer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Build one file of the given kind into file_buf. Content is random apart from
    // the bytes that steer format detection and the JPEG segment walk.
    function automatic void make_file(file_kind_t kind);
        int          seg_len;
        int          stop_at;
        logic [7:0]  mk;
        file_buf.delete();
        case (kind)
            F_SHORT: begin
                repeat ($urandom_range(1, 23)) file_buf.push_back(8'($urandom));
            end
            F_NOISE: begin
                repeat ($urandom_range(24, 36)) file_buf.push_back(8'($urandom));
            end
            F_GIF: begin
                file_buf.push_back("G");
                file_buf.push_back("I");
                file_buf.push_back("F");
                repeat ($urandom_range(21, 33)) file_buf.push_back(8'($urandom));
                // break the tag now and then
                if ($urandom_range(0, 7) == 0)
                    file_buf[$urandom_range(0, 2)] = 8'($urandom);
            end
            F_PNG: begin
                for (int i = 7; i >= 0; i--) file_buf.push_back(PNG_SIGNATURE[i*8 +: 8]);
                repeat (4) file_buf.push_back(8'($urandom));
                file_buf.push_back("I");
                file_buf.push_back("H");
                file_buf.push_back("D");
                file_buf.push_back("R");
                repeat ($urandom_range(8, 16)) file_buf.push_back(8'($urandom));
                if ($urandom_range(0, 5) == 0)
                    file_buf[$urandom_range(0, 15)] = 8'($urandom);
            end
            F_JPEG: begin
                // SOI and a marker prefix, but almost never a JFIF APP0
                file_buf.push_back(MARK_PREFIX);
                file_buf.push_back(MARK_SOI);
                file_buf.push_back(MARK_PREFIX);
                repeat ($urandom_range(21, 33)) file_buf.push_back(8'($urandom));
            end
            default: begin
                // JFIF: APP0, a few plain segments, then a frame marker, a broken
                // prefix or nothing. A rare huge APP0 length leaves the walk hanging.
                seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16'hFFFF)
                                                      : $urandom_range(8, 24);
                file_buf.push_back(MARK_PREFIX);
                file_buf.push_back(MARK_SOI);
                file_buf.push_back(MARK_PREFIX);
                file_buf.push_back(MARK_APP0);
                file_buf.push_back(seg_len[15:8]);
                file_buf.push_back(seg_len[7:0]);
                file_buf.push_back("J");
                file_buf.push_back("F");
                file_buf.push_back("I");
                file_buf.push_back("F");
                while (file_buf.size() < 4 + seg_len && file_buf.size() < MAX_FILE)
                    file_buf.push_back(8'($urandom));
                repeat ($urandom_range(0, 3)) begin
                    mk = 8'($urandom);
                    if (is_frame_marker(mk))
                        mk = MARK_APP0;
                    seg_len = $urandom_range(2, 14);
                    file_buf.push_back(MARK_PREFIX);
                    file_buf.push_back(mk);
                    file_buf.push_back(8'h00);
                    file_buf.push_back(seg_len[7:0]);
                    repeat (seg_len - 2) file_buf.push_back(8'($urandom));
                end
                case ($urandom_range(0, 3))
                    0, 1: begin
                        case ($urandom_range(0, 6))
                            0:       mk = MARK_SOF0;
                            1:       mk = MARK_SOF1;
                            2:       mk = MARK_SOF2;
                            3:       mk = MARK_SOF3;
                            4:       mk = MARK_SOF9;
                            5:       mk = MARK_SOF10;
                            default: mk = MARK_SOF11;
                        endcase
                        file_buf.push_back(MARK_PREFIX);
                        file_buf.push_back(mk);
                        // length, precision, height, width, components
                        repeat (8) file_buf.push_back(8'($urandom));
                    end
                    2:       file_buf.push_back(8'($urandom_range(0, 8'hFE)));
                    default: ;
                endcase
                repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom));
                // cut some files short so they end mid-walk
                if ($urandom_range(0, 4) == 0) begin
                    stop_at = $urandom_range(1, file_buf.size());
                    while (file_buf.size() > stop_at) void'(file_buf.pop_back());
                end
                while (file_buf.size() > MAX_FILE) void'(file_buf.pop_back());
            end
        endcase
    endfunction

    // Offer one byte and hold it until accepted. Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(b, last);
        @(negedge aclk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
    endtask

    // Drop valid and wait for every pending result, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.sizes_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write both default-size registers on back-to-back cycles; call only when idle.
    task automatic set_defaults(input logic [15:0] w, input logic [15:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEFAULT_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= CFG_DEFAULT_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_default(CFG_DEFAULT_WIDTH, w);
        tracker.set_default(CFG_DEFAULT_HEIGHT, h);
    endtask

    // Result side: random stalls, one long hold on request, check on every taken beat.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready)
                tracker.check_size(m_tdata);
            @(negedge aclk);
        end
    end

    // Stimulus
    initial begin
        int          n_bytes;
        int          k;
        file_kind_t  kind;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_DEFAULT_WIDTH;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        tracker   = new();
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one-byte files at both byte extremes (default size from reset),
        // then a GIF of exactly 24 bytes with the widest width and a zero height.
        file_buf = '{8'h00};
        send_file();
        file_buf = '{8'hFF};
        send_file();
        file_buf.delete();
        file_buf.push_back("G");
        file_buf.push_back("I");
        file_buf.push_back("F");
        file_buf.push_back("8");
        file_buf.push_back("9");
        file_buf.push_back("a");
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'h00);
        while (file_buf.size() < 24) file_buf.push_back(8'($urandom));
        send_file();

        // Random files under six register settings: reset values, both extremes,
        // then random ones. Phase 3 runs without idling and the last phase too.
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0:       ;
                1:       set_defaults(16'h0000, 16'h0000);
                2:       set_defaults(16'hFFFF, 16'hFFFF);
                default: set_defaults(16'($urandom), 16'($urandom));
            endcase
            tx_idle = (p != 3) && (p != 5);
            rx_idle = tx_idle;

            if (p == 2) begin
                // Hold the result side while short files stream back to back,
                // so the result buffer fills and the input stalls.
                hold_cycles = 200;
                tx_idle = 1'b0;
                repeat (30) begin
                    make_file(F_SHORT);
                    send_file();
                end
                tx_idle = 1'b1;
            end

            n_bytes = 0;
            while (n_bytes < PHASE_BYTES) begin
                k = $urandom_range(0, 99);
                if (k < 40)      kind = F_JFIF;
                else if (k < 50) kind = F_JPEG;
                else if (k < 62) kind = F_PNG;
                else if (k < 74) kind = F_GIF;
                else if (k < 88) kind = F_SHORT;
                else             kind = F_NOISE;
                make_file(kind);
                n_bytes += file_buf.size();
                send_file();
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (tracker.errors == 0 && tracker.sizes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
